// File: rtl/one_shot_drum_sample_player_defines.svh
// Assertion macros shared by the drum sample player RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef ONE_SHOT_DRUM_SAMPLE_PLAYER_DEFINES_SVH
`define ONE_SHOT_DRUM_SAMPLE_PLAYER_DEFINES_SVH

// Check an expression at every clock edge outside reset.
`define OSDSP_ASSERT_ALWAYS(label, clk_s, rstn_s, expr, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (expr)) else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define OSDSP_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/osdsp_pkg.sv
// Shared types, codes and constants of the drum sample player.
// No dependencies; the sample store, controller, output stage and top level import it.
package osdsp_pkg;

    localparam int PHASE_W    = 31;
    localparam int FRAC_W     = 16;
    localparam int PITCH_W    = 11;
    localparam int STEP_W     = 19;
    localparam int LEN_W      = 16;
    localparam int CNT_W      = 20;
    localparam int SAMPLE_W   = 16;
    localparam int DUTY_W     = 10;
    localparam int REQ_W      = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;

    localparam logic [7:0]       PHASE_STEP_MUL = 8'd131;
    localparam logic [CNT_W-1:0] COUNT_MAX      = 20'hFFFFF;
    localparam logic [LEN_W-1:0] LEN_RESET      = 16'd28800;
    localparam logic [CNT_W-1:0] DELAY_RESET    = 20'd240000;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK   = 3'd0,
        REQ_GATE   = 3'd1,
        REQ_DETENT = 3'd2,
        REQ_PITCH  = 3'd3,
        REQ_WRITE  = 3'd4
    } req_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PLAY_LENGTH = 1'b0,
        CFG_SAVE_DELAY  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic is_tick;
        logic playing;
        logic save_now;
    } meta_t;

    function automatic logic [DUTY_W-1:0] duty_of(input logic [SAMPLE_W-1:0] raw);
        logic [DUTY_W-1:0] ob;
        ob = {~raw[SAMPLE_W-1], raw[SAMPLE_W-2:SAMPLE_W-DUTY_W]};
        return (ob == '0) ? '0 : ob - 1'b1;
    endfunction

endpackage

// File: rtl/osdsp_req_if.sv
// Request channel of the drum sample player: valid/ready plus request payload.
// Depends on nothing; widths of voice and position follow the parameters.
interface osdsp_req_if #(
    parameter int VOICE_W = 6,
    parameter int ADDR_W  = 15
);
    logic                valid;
    logic                ready;
    logic [2:0]          req_type;
    logic                gate_level;
    logic                turn_dir;
    logic [10:0]         pitch_sum;
    logic [VOICE_W-1:0]  mem_voice;
    logic [ADDR_W-1:0]   mem_addr;
    logic signed [15:0]  mem_data;

    modport source (
        output valid, req_type, gate_level, turn_dir, pitch_sum, mem_voice, mem_addr,
               mem_data,
        input  ready
    );
    modport sink (
        input  valid, req_type, gate_level, turn_dir, pitch_sum, mem_voice, mem_addr,
               mem_data,
        output ready
    );
endinterface

// File: rtl/osdsp_res_if.sv
// Result channel of the drum sample player: valid/ready plus result payload.
// Depends on nothing; the voice width follows the parameter.
interface osdsp_res_if #(
    parameter int VOICE_W = 6
);
    logic               valid;
    logic               ready;
    logic [9:0]         pwm_duty;
    logic               playing;
    logic [VOICE_W-1:0] voice;
    logic               save_now;

    modport source (
        output valid, pwm_duty, playing, voice, save_now,
        input  ready
    );
    modport sink (
        input  valid, pwm_duty, playing, voice, save_now,
        output ready
    );
endinterface

// File: rtl/osdsp_sample_mem.sv
// Sample store: one write port, one registered read port, no reset.
// Depends on osdsp_pkg for the sample width.
module osdsp_sample_mem #(
    parameter int DEPTH = 1572864,
    parameter int AW    = 21
) (
    input  logic                           clk,
    input  logic                           we,
    input  logic [AW-1:0]                  waddr,
    input  logic [osdsp_pkg::SAMPLE_W-1:0] wdata,
    input  logic                           rd_en,
    input  logic [AW-1:0]                  rd_addr,
    output logic [osdsp_pkg::SAMPLE_W-1:0] rd_data
);
    import osdsp_pkg::*;

    logic [SAMPLE_W-1:0] mem_array [DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;

    // read returns the old word when the same entry is written at the same edge
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/osdsp_ctrl.sv
// Request decode and voice state: phase, gate, voice, save timer, config registers.
// Issues sample reads and writes. Depends on osdsp_pkg, osdsp_req_if and the defines.
`include "one_shot_drum_sample_player_defines.svh"

module osdsp_ctrl #(
    parameter int NUM_VOICES   = 48,
    parameter int SAMPLE_DEPTH = 32768,
    parameter int VOICE_W      = 6,
    parameter int ADDR_W       = 15,
    parameter int MEM_AW       = 21
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [osdsp_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [osdsp_pkg::CFG_DATA_W-1:0] cfg_wdata,
    osdsp_req_if.sink                        req,
    input  logic                             s2_ready,
    output logic                             s1_valid,
    output osdsp_pkg::meta_t                 s1_meta,
    output logic [VOICE_W-1:0]               s1_voice,
    output logic                             rd_en,
    output logic [MEM_AW-1:0]                rd_addr,
    output logic                             we,
    output logic [MEM_AW-1:0]                waddr,
    output logic [osdsp_pkg::SAMPLE_W-1:0]   wdata
);
    import osdsp_pkg::*;

    localparam int RED_W = ADDR_W + 5;
    localparam logic [VOICE_W:0]    VOICE_LIM  = (VOICE_W + 1)'(NUM_VOICES);
    localparam logic [ADDR_W:0]     DEPTH_LIM  = (ADDR_W + 1)'(SAMPLE_DEPTH);
    localparam logic [VOICE_W-1:0]  VOICE_LAST = VOICE_W'(NUM_VOICES - 1);
    localparam logic [MEM_AW-1:0]   BASE_STEP  = MEM_AW'(SAMPLE_DEPTH);
    localparam logic [MEM_AW-1:0]   BASE_LAST  = MEM_AW'((NUM_VOICES - 1) * SAMPLE_DEPTH);
    localparam logic [RED_W-1:0]    DEPTH_RED  = RED_W'(SAMPLE_DEPTH);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               play_reg, play_next;
    logic [VOICE_W-1:0] voice_reg, voice_next;
    logic [MEM_AW-1:0]  base_reg, base_next;
    logic               last_gate_reg, last_gate_next;
    logic [PITCH_W-1:0] pitch_reg, pitch_next;
    logic               save_pending_reg, save_pending_next;
    logic [CNT_W-1:0]   save_count_reg, save_count_next;
    logic [LEN_W-1:0]   play_length_reg;
    logic [CNT_W-1:0]   save_delay_reg;
    logic               s1_valid_reg, s1_valid_next;
    meta_t              s1_meta_reg, s1_meta_next;
    logic [VOICE_W-1:0] s1_voice_reg;

    logic               accept;
    logic               s1_adv;
    logic [STEP_W-1:0]  step;
    logic [31:0]        sum;
    logic [CNT_W-1:0]   cnt_inc;
    logic               save_now;
    logic [RED_W-1:0]   red;

    assign req.ready = !s1_valid_reg || s2_ready;
    assign accept    = req.valid && req.ready;
    assign s1_adv    = s1_valid_reg && s2_ready;

    assign step    = STEP_W'(pitch_reg) * STEP_W'(PHASE_STEP_MUL);
    assign sum     = {1'b0, phase_reg} + 32'(step);
    assign cnt_inc = (save_count_reg == COUNT_MAX) ? save_count_reg : save_count_reg + 1'b1;

    always_comb
    begin
        phase_next        = phase_reg;
        play_next         = play_reg;
        voice_next        = voice_reg;
        base_next         = base_reg;
        last_gate_next    = last_gate_reg;
        pitch_next        = pitch_reg;
        save_pending_next = save_pending_reg;
        save_count_next   = save_count_reg;
        save_now          = 1'b0;
        if (accept)
        begin
            unique case (req.req_type)
                REQ_TICK:
                begin
                    if (play_reg)
                    begin
                        if (sum[31:FRAC_W] >= play_length_reg)
                        begin
                            phase_next = '0;
                            play_next  = 1'b0;
                        end
                        else
                        begin
                            phase_next = sum[PHASE_W-1:0];
                        end
                    end
                    if (save_pending_reg)
                    begin
                        save_count_next = cnt_inc;
                        if (cnt_inc >= save_delay_reg)
                        begin
                            save_now          = 1'b1;
                            save_pending_next = 1'b0;
                        end
                    end
                end
                REQ_GATE:
                begin
                    if (req.gate_level && !last_gate_reg)
                    begin
                        play_next  = 1'b1;
                        phase_next = '0;
                    end
                    last_gate_next = req.gate_level;
                end
                REQ_DETENT:
                begin
                    if (req.turn_dir)
                    begin
                        if (voice_reg == '0)
                        begin
                            voice_next = VOICE_LAST;
                            base_next  = BASE_LAST;
                        end
                        else
                        begin
                            voice_next = voice_reg - 1'b1;
                            base_next  = base_reg - BASE_STEP;
                        end
                    end
                    else
                    begin
                        if (voice_reg == VOICE_LAST)
                        begin
                            voice_next = '0;
                            base_next  = '0;
                        end
                        else
                        begin
                            voice_next = voice_reg + 1'b1;
                            base_next  = base_reg + BASE_STEP;
                        end
                    end
                    play_next         = 1'b1;
                    phase_next        = '0;
                    save_count_next   = '0;
                    save_pending_next = 1'b1;
                end
                REQ_PITCH:
                begin
                    pitch_next = req.pitch_sum;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_meta_next  = s1_meta_reg;
        if (req.ready)
        begin
            s1_valid_next         = accept;
            s1_meta_next.is_tick  = (req.req_type == REQ_TICK);
            s1_meta_next.playing  = play_next;
            s1_meta_next.save_now = save_now;
        end
    end

    // reduce the integer position modulo the sample depth, one compare-subtract per bit
    always_comb
    begin
        red = RED_W'(phase_reg[PHASE_W-1:FRAC_W]);
        for (int k = 4; k >= 0; k--)
        begin
            if (red >= (DEPTH_RED << k))
            begin
                red = red - (DEPTH_RED << k);
            end
        end
    end

    // state only changes when s1 is empty or moves on, so the address matches the item in s1
    assign rd_en   = s1_adv && s1_meta_reg.is_tick;
    assign rd_addr = base_reg + MEM_AW'(red[ADDR_W-1:0]);

    assign we    = accept && (req.req_type == REQ_WRITE)
                   && ({1'b0, req.mem_voice} < VOICE_LIM)
                   && ({1'b0, req.mem_addr} < DEPTH_LIM);
    assign waddr = MEM_AW'(req.mem_voice) * BASE_STEP + MEM_AW'(req.mem_addr);
    assign wdata = $unsigned(req.mem_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= '0;
            play_reg         <= 1'b0;
            voice_reg        <= '0;
            base_reg         <= '0;
            last_gate_reg    <= 1'b0;
            pitch_reg        <= '0;
            save_pending_reg <= 1'b0;
            save_count_reg   <= '0;
            s1_valid_reg     <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            play_reg         <= play_next;
            voice_reg        <= voice_next;
            base_reg         <= base_next;
            last_gate_reg    <= last_gate_next;
            pitch_reg        <= pitch_next;
            save_pending_reg <= save_pending_next;
            save_count_reg   <= save_count_next;
            s1_valid_reg     <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_meta_reg <= s1_meta_next;
        if (accept)
        begin
            s1_voice_reg <= voice_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            play_length_reg <= LEN_RESET;
            save_delay_reg  <= DELAY_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx)
                CFG_PLAY_LENGTH: play_length_reg <= cfg_wdata[LEN_W-1:0];
                CFG_SAVE_DELAY:  save_delay_reg  <= cfg_wdata[CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_meta  = s1_meta_reg;
    assign s1_voice = s1_voice_reg;

    `OSDSP_ASSERT_ALWAYS(a_voice_range, clk, rst_n, {1'b0, voice_reg} < VOICE_LIM,
        "voice out of range")
    `OSDSP_ASSERT_ALWAYS(a_base_match, clk, rst_n,
        base_reg == MEM_AW'(voice_reg) * BASE_STEP, "voice base out of step")
    `OSDSP_ASSERT_ALWAYS(a_idle_phase, clk, rst_n, play_reg || (phase_reg == '0),
        "phase nonzero while stopped")
    `OSDSP_ASSERT_NEXT(a_hold_state, clk, rst_n, s1_valid_reg && !s2_ready,
        $stable(phase_reg) && $stable(base_reg), "state moved under a pending read")

endmodule

// File: rtl/osdsp_out.sv
// Read-data stage and output register: forms the PWM duty and drives the result channel.
// Depends on osdsp_pkg and osdsp_res_if.
module osdsp_out #(
    parameter int VOICE_W = 6
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s1_valid,
    input  osdsp_pkg::meta_t               s1_meta,
    input  logic [VOICE_W-1:0]             s1_voice,
    input  logic [osdsp_pkg::SAMPLE_W-1:0] rd_data,
    output logic                           s2_ready,
    osdsp_res_if.source                    rsp
);
    import osdsp_pkg::*;

    logic               s2_valid_reg;
    meta_t              s2_meta_reg;
    logic [VOICE_W-1:0] s2_voice_reg;
    logic               out_valid_reg;
    logic [DUTY_W-1:0]  duty_reg;
    logic               playing_reg;
    logic [VOICE_W-1:0] voice_reg;
    logic               save_reg;
    logic               out_free;

    assign out_free = !out_valid_reg || rsp.ready;
    assign s2_ready = !s2_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // hold payload while the receiver stalls
    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid)
        begin
            s2_meta_reg  <= s1_meta;
            s2_voice_reg <= s1_voice;
        end
        if (out_free && s2_valid_reg)
        begin
            duty_reg    <= s2_meta_reg.is_tick ? duty_of(rd_data) : '0;
            playing_reg <= s2_meta_reg.playing;
            voice_reg   <= s2_voice_reg;
            save_reg    <= s2_meta_reg.save_now;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.pwm_duty = duty_reg;
    assign rsp.playing  = playing_reg;
    assign rsp.voice    = voice_reg;
    assign rsp.save_now = save_reg;

endmodule

// File: rtl/one_shot_drum_sample_player.sv
// One-shot drum sample player.
// Channels: req (sink) takes requests; rsp (source) gives one result per request.
// Config: cfg_wr_en/cfg_idx/cfg_wdata write play_length (0) and save_delay_ticks (1).
// Every request gives exactly one result, in order: ticks read one sample and
// return its PWM duty, other requests return duty 0 with the updated state.
// Path: each request passes the decode, sample read and output registers in that order.
// Throughput: one request per cycle unless rsp stalls; a tick occupies the single sample
// memory read port as it leaves the decode stage, after its state update; stages overlap.
// Samples are written one word per request; entries never written read as garbage.
// Reset: phase, playback, voice, gate history, pitch and the save timer clear;
// play_length returns to 28800 and save_delay_ticks to 240000; the sample
// memory keeps its contents and needs no clearing pass.
// Stall: a result waiting in the output register blocks only when the read and
// decode stages behind it are full too; then req.ready drops until rsp transfers.
// The user must write configuration only while no request is in flight; not enforced here.
module one_shot_drum_sample_player #(
    parameter int NUM_VOICES   = 48,
    parameter int SAMPLE_DEPTH = 32768
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [osdsp_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [osdsp_pkg::CFG_DATA_W-1:0] cfg_wdata,
    osdsp_req_if.sink                        req,
    osdsp_res_if.source                      rsp
);
    import osdsp_pkg::*;

    localparam int VOICE_W   = $clog2(NUM_VOICES);
    localparam int ADDR_W    = $clog2(SAMPLE_DEPTH);
    localparam int MEM_DEPTH = NUM_VOICES * SAMPLE_DEPTH;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    logic                s2_ready;
    logic                s1_valid;
    meta_t               s1_meta;
    logic [VOICE_W-1:0]  s1_voice;
    logic                rd_en;
    logic [MEM_AW-1:0]   rd_addr;
    logic                we;
    logic [MEM_AW-1:0]   waddr;
    logic [SAMPLE_W-1:0] wdata;
    logic [SAMPLE_W-1:0] rd_data;

    osdsp_ctrl #(
        .NUM_VOICES   (NUM_VOICES),
        .SAMPLE_DEPTH (SAMPLE_DEPTH),
        .VOICE_W      (VOICE_W),
        .ADDR_W       (ADDR_W),
        .MEM_AW       (MEM_AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .s2_ready  (s2_ready),
        .s1_valid  (s1_valid),
        .s1_meta   (s1_meta),
        .s1_voice  (s1_voice),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .we        (we),
        .waddr     (waddr),
        .wdata     (wdata)
    );

    osdsp_sample_mem #(
        .DEPTH (MEM_DEPTH),
        .AW    (MEM_AW)
    ) u_mem (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    osdsp_out #(
        .VOICE_W (VOICE_W)
    ) u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid),
        .s1_meta  (s1_meta),
        .s1_voice (s1_voice),
        .rd_data  (rd_data),
        .s2_ready (s2_ready),
        .rsp      (rsp)
    );

endmodule
